FILE: design/fqvd_pkg.sv
// Shared codes, field widths and state type for the linked-list FIFO queue.
package fqvd_pkg;

    // Field widths fixed by the stream format
    localparam int VAL_W    = 32;
    localparam int REQ_W    = 2;
    localparam int ST_W     = 2;
    localparam int OCC_W    = 5;
    localparam int M_DATA_W = 40;

    typedef logic [REQ_W-1:0] req_code_t;
    typedef logic [ST_W-1:0]  status_t;

    // Request codes
    localparam req_code_t REQ_ENQ = 2'd0;
    localparam req_code_t REQ_DEQ = 2'd1;
    localparam req_code_t REQ_DEL = 2'd2;

    // Result status codes
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_EMPTY     = 2'd1;
    localparam status_t ST_NOT_FOUND = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

    // Value returned by a dequeue from an empty queue
    localparam logic [VAL_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_FIX
    } state_t;

endpackage

FILE: design/fqvd_store.sv
// Entry store: value memory and link memory sharing one read address, with registered read data.
module fqvd_store #(
    parameter int   DEPTH = 16,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [fqvd_pkg::VAL_W-1:0] rd_value,
    output logic [AW-1:0]              rd_link,
    input  logic                       val_we,
    input  logic [AW-1:0]              val_waddr,
    input  logic [fqvd_pkg::VAL_W-1:0] val_wdata,
    input  logic                       link_we,
    input  logic [AW-1:0]              link_waddr,
    input  logic [AW-1:0]              link_wdata
);
    import fqvd_pkg::*;

    logic [VAL_W-1:0] value_mem [DEPTH];
    logic [AW-1:0]    link_mem  [DEPTH];

    // Write values
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            value_mem[val_waddr] <= val_wdata;
        end
    end

    // Write links
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
    end

    // Read both memories; data holds when no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_value <= value_mem[rd_addr];
            rd_link  <= link_mem[rd_addr];
        end
    end

endmodule

FILE: design/fifo_queue_with_value_delete_top.sv
// Top level of the bounded FIFO queue with enqueue, dequeue and delete-by-value.
// Entries live in a linked list kept in two one-port-read memories (values and links);
// released slots go onto a free list threaded through the link memory, and never-used
// slots are handed out by a fill counter, so no clearing pass follows reset. Enqueue, dequeue,
// the unused code, any request that fails at once and a delete that hits the front entry are
// accepted, then committed. A delete that misses the front walks the list behind it, then
// unlinks and releases the matching slot in a fix step, or reports not found at the tail.
// The walk advances one link per cycle while the output register is free, set by the single
// read port of the link memory. A result waiting on m_tready holds the commit of the next
// request until the output register frees up.
module fifo_queue_with_value_delete_top #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fqvd_pkg::VAL_W-1:0]    s_tdata,   // [31:0] value
    input  logic [fqvd_pkg::REQ_W-1:0]    s_tuser,   // [1:0] req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fqvd_pkg::M_DATA_W-1:0] m_tdata,   // [31:0] out_value, [32] now_empty,
                                                     // [37:33] occupancy, [39:38] zero
    output logic [fqvd_pkg::ST_W-1:0]     m_tuser    // [1:0] status
);
    import fqvd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);
    localparam int PAD_W = M_DATA_W - VAL_W - 1 - OCC_W;

    state_t state_reg, state_next;

    req_code_t        req_reg, req_next;
    logic [VAL_W-1:0] val_reg, val_next;

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] free_head_reg, free_head_next;
    logic [AW-1:0] prev_reg, prev_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] fresh_reg, fresh_next;
    logic [CW-1:0] idx_reg, idx_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    status_t             m_tuser_reg, m_tuser_next;

    // Memory port signals
    logic             mem_re;
    logic [AW-1:0]    mem_ra;
    logic [VAL_W-1:0] rd_value;
    logic [AW-1:0]    rd_link;
    logic             val_we;
    logic [AW-1:0]    val_wa;
    logic [VAL_W-1:0] val_wd;
    logic             link_we;
    logic [AW-1:0]    link_wa;
    logic [AW-1:0]    link_wd;

    // Result being loaded this cycle
    logic             load_out;
    status_t          res_status;
    logic [VAL_W-1:0] res_value;

    logic          out_free;
    logic          hit;
    logic          walk_last;
    logic          start_walk;
    logic [AW-1:0] new_slot;

    fqvd_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk        (clk),
        .rd_en      (mem_re),
        .rd_addr    (mem_ra),
        .rd_value   (rd_value),
        .rd_link    (rd_link),
        .val_we     (val_we),
        .val_waddr  (val_wa),
        .val_wdata  (val_wd),
        .link_we    (link_we),
        .link_waddr (link_wa),
        .link_wdata (link_wd)
    );

    // Status terms shared by the sequencer blocks
    assign out_free   = !m_tvalid_reg || m_tready;
    assign hit        = (rd_value == val_reg);
    assign walk_last  = (idx_reg == count_reg - ONE_CNT);
    assign start_walk = (req_reg == REQ_DEL) && (count_reg > ONE_CNT) && !hit;
    assign new_slot   = (fresh_reg != FULL_CNT) ? fresh_reg[AW-1:0] : free_head_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = start_walk ? S_WALK : S_IDLE;
                end
            end
            S_WALK:
            begin
                if (out_free)
                begin
                    if (hit)
                    begin
                        state_next = S_FIX;
                    end
                    else if (walk_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FIX:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        req_next       = req_reg;
        val_next       = val_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        count_next     = count_reg;
        fresh_next     = fresh_reg;
        idx_next       = idx_reg;
        mem_re         = 1'b0;
        mem_ra         = head_reg;
        val_we         = 1'b0;
        val_wa         = new_slot;
        val_wd         = val_reg;
        link_we        = 1'b0;
        link_wa        = tail_reg;
        link_wd        = new_slot;
        load_out       = 1'b0;
        res_status     = ST_OK;
        res_value      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Capture the beat and fetch the free-list head or the queue front
                if (s_tvalid)
                begin
                    req_next = s_tuser;
                    val_next = s_tdata;
                    mem_re   = 1'b1;
                    mem_ra   = (s_tuser == REQ_ENQ) ? free_head_reg : head_reg;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    case (req_reg) inside
                        REQ_ENQ:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                // Take a never-used slot first, else pop the free list
                                if (fresh_reg != FULL_CNT)
                                begin
                                    fresh_next = fresh_reg + ONE_CNT;
                                end
                                else
                                begin
                                    free_head_next = rd_link;
                                end
                                val_we = 1'b1;
                                if (count_reg != '0)
                                begin
                                    link_we = 1'b1;
                                end
                                else
                                begin
                                    head_next = new_slot;
                                end
                                tail_next  = new_slot;
                                count_next = count_reg + ONE_CNT;
                            end
                        end
                        REQ_DEQ, REQ_DEL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = ST_EMPTY;
                                res_value  = (req_reg == REQ_DEQ) ? EMPTY_VALUE : '0;
                            end
                            else if (req_reg == REQ_DEQ || hit)
                            begin
                                // Drop the front entry and push its slot on the free list
                                res_value      = (req_reg == REQ_DEQ) ? rd_value : '0;
                                head_next      = rd_link;
                                link_we        = 1'b1;
                                link_wa        = head_reg;
                                link_wd        = free_head_reg;
                                free_head_next = head_reg;
                                count_next     = count_reg - ONE_CNT;
                            end
                            else if (count_reg == ONE_CNT)
                            begin
                                res_status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                // Advance to the second entry
                                load_out  = 1'b0;
                                prev_next = head_reg;
                                cur_next  = rd_link;
                                idx_next  = ONE_CNT;
                                mem_re    = 1'b1;
                                mem_ra    = rd_link;
                            end
                        end
                        default:
                        begin
                            res_status = ST_OK;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (out_free)
                begin
                    if (hit)
                    begin
                        // Unlink the matching entry from its predecessor
                        link_we = 1'b1;
                        link_wa = prev_reg;
                        link_wd = rd_link;
                        if (walk_last)
                        begin
                            tail_next = prev_reg;
                        end
                    end
                    else if (walk_last)
                    begin
                        load_out   = 1'b1;
                        res_status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        prev_next = cur_reg;
                        cur_next  = rd_link;
                        idx_next  = idx_reg + ONE_CNT;
                        mem_re    = 1'b1;
                        mem_ra    = rd_link;
                    end
                end
            end
            S_FIX:
            begin
                // Release the unlinked slot onto the free list
                if (out_free)
                begin
                    load_out       = 1'b1;
                    link_we        = 1'b1;
                    link_wa        = cur_reg;
                    link_wd        = free_head_reg;
                    free_head_next = cur_reg;
                    count_next     = count_reg - ONE_CNT;
                end
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = res_status;
            m_tdata_next  = {{PAD_W{1'b0}}, OCC_W'(count_next), (count_next == '0), res_value};
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_head_reg <= '0;
            count_reg     <= '0;
            fresh_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        val_reg     <= val_next;
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // Occupancy never exceeds the slot count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above depth");

    // Every live entry came from a slot handed out by the fill counter
    a_fresh_covers: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg >= count_reg)
        else $error("fill counter below entry count");

    // The walk stays inside the live list
    a_walk_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (idx_reg < count_reg))
        else $error("delete walk ran past the tail");

    // A pending result reports the current occupancy
    a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_tdata_reg[VAL_W+OCC_W:VAL_W+1] == OCC_W'(count_reg)))
        else $error("reported occupancy differs from entry count");

endmodule

FILE: test/fifo_queue_with_value_delete_top_tb.sv
// Self-checking testbench for the bounded FIFO queue with enqueue, dequeue and delete-by-value.
module fifo_queue_with_value_delete_top_tb;

    import fqvd_pkg::*;

    localparam int QDEPTH       = 16;
    localparam int RAND_ITEMS   = 500;   // per idling phase
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 40;

    // Request code the block ignores apart from reporting its state
    localparam req_code_t REQ_NONE = 2'd3;

    typedef struct packed {
        status_t          status;
        logic [VAL_W-1:0] out_value;
        logic             now_empty;
        logic [OCC_W-1:0] occupancy;
    } req_result_t;

    typedef struct packed {
        req_code_t        req;
        logic [VAL_W-1:0] value;
        logic [4:0]       reps;     // repeat count, value steps by one per repeat
        logic             known;    // result typed in below
        req_result_t      res;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [VAL_W-1:0]    s_tdata = '0;
    logic [REQ_W-1:0]    s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [ST_W-1:0]     m_tuser;

    // Predicted queue contents, front at index 0
    logic [VAL_W-1:0] held_vals[$];
    req_result_t      pending_results[$];
    stim_row_t        dir_rows[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_request   = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned mismatch_count = 0;
    int unsigned reqs_sent      = 0;
    int unsigned results_seen   = 0;
    int unsigned status_seen[4] = '{0, 0, 0, 0};
    req_result_t want;

    fifo_queue_with_value_delete_top #(
        .DEPTH(QDEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the predicted queue and return the result it gives
    function automatic req_result_t apply_request(input req_code_t rq, input logic [VAL_W-1:0] v);
        req_result_t r;
        int          hit;
        r.status    = ST_OK;
        r.out_value = '0;
        hit         = -1;
        case (rq)
            REQ_ENQ:
            begin
                if (held_vals.size() >= QDEPTH)
                    r.status = ST_FULL;
                else
                    held_vals.push_back(v);
            end
            REQ_DEQ:
            begin
                if (held_vals.size() == 0)
                begin
                    r.status    = ST_EMPTY;
                    r.out_value = EMPTY_VALUE;
                end
                else
                    r.out_value = held_vals.pop_front();
            end
            REQ_DEL:
            begin
                if (held_vals.size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    // find the first match counted from the front
                    for (int i = 0; i < held_vals.size(); i++)
                        if (hit < 0 && held_vals[i] == v)
                            hit = i;
                    if (hit < 0)
                        r.status = ST_NOT_FOUND;
                    else
                        held_vals.delete(hit);
                end
            end
            default: ;
        endcase
        r.now_empty = (held_vals.size() == 0);
        r.occupancy = OCC_W'(held_vals.size());
        return r;
    endfunction

    // Offer one beat, wait for acceptance, then log its expected result
    task automatic send_req(input req_code_t rq, input logic [VAL_W-1:0] v,
                            input logic known, input req_result_t typed);
        req_result_t pred;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = apply_request(rq, v);
        pending_results.push_back(known ? typed : pred);
        reqs_sent++;
    endtask

    // Hold the sender until every expected result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Random requests, with the enqueue share switching so the queue swings full and empty
    task automatic run_random(input int unsigned n_items);
        int unsigned      enq_pct;
        int unsigned      roll;
        req_code_t        rq;
        logic [VAL_W-1:0] v;
        enq_pct = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 64 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       enq_pct = 25;
                    1:       enq_pct = 50;
                    default: enq_pct = 85;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
                rq = REQ_NONE;
            else if (roll < enq_pct)
                rq = REQ_ENQ;
            else if ($urandom_range(0, 1) == 1)
                rq = REQ_DEQ;
            else
                rq = REQ_DEL;
            // mostly a small value pool so deletes hit and duplicates occur
            if ($urandom_range(0, 3) == 0)
                v = $urandom;
            else if (rq == REQ_DEL && held_vals.size() > 0 && $urandom_range(0, 1) == 1)
                v = held_vals[$urandom_range(0, held_vals.size() - 1)];
            else
                v = ($urandom_range(0, 1) == 1 ? 32'hFFFF_FFF8 : 32'h0) | $urandom_range(0, 7);
            send_req(rq, v, 1'b0, '0);
        end
    endtask

    // Check each result beat against the oldest expectation; drive m_tready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            status_seen[m_tuser]++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: status %0d data %h", m_tuser, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[31:0] !== want.out_value)
                begin
                    $error("out_value: expected %h, got %h", want.out_value, m_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_tdata[32] !== want.now_empty)
                begin
                    $error("now_empty: expected %0d, got %0d", want.now_empty, m_tdata[32]);
                    mismatch_count++;
                end
                if (m_tdata[37:33] !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, m_tdata[37:33]);
                    mismatch_count++;
                end
            end
        end
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // End the run if it hangs
    initial
    begin
        #5_000_000;
        $display("fifo_queue_with_value_delete_top_tb: done, errors");
        $finish;
    end

    initial
    begin
        // directed rows: empty cases, extremes, fill to full, deletes at tail, middle, front
        dir_rows.push_back('{REQ_DEQ, 32'h0, 5'd1, 1'b1, '{ST_EMPTY, EMPTY_VALUE, 1'b1, 5'd0}});
        dir_rows.push_back('{REQ_DEL, 32'd5, 5'd1, 1'b1, '{ST_EMPTY, 32'h0, 1'b1, 5'd0}});
        dir_rows.push_back('{REQ_NONE, 32'h1234_5678, 5'd1, 1'b1, '{ST_OK, 32'h0, 1'b1, 5'd0}});
        dir_rows.push_back('{REQ_ENQ, 32'h8000_0000, 5'd1, 1'b1, '{ST_OK, 32'h0, 1'b0, 5'd1}});
        dir_rows.push_back('{REQ_ENQ, 32'h7FFF_FFFF, 5'd1, 1'b1, '{ST_OK, 32'h0, 1'b0, 5'd2}});
        dir_rows.push_back('{REQ_ENQ, 32'hFFFF_FFFF, 5'd1, 1'b1, '{ST_OK, 32'h0, 1'b0, 5'd3}});
        dir_rows.push_back('{REQ_ENQ, 32'h0, 5'd1, 1'b1, '{ST_OK, 32'h0, 1'b0, 5'd4}});
        dir_rows.push_back('{REQ_ENQ, 32'd100, 5'd12, 1'b0, '0});
        dir_rows.push_back('{REQ_ENQ, 32'hAAAA_AAAA, 5'd1, 1'b1, '{ST_FULL, 32'h0, 1'b0, 5'd16}});
        dir_rows.push_back('{REQ_NONE, 32'h0, 5'd1, 1'b1, '{ST_OK, 32'h0, 1'b0, 5'd16}});
        dir_rows.push_back('{REQ_DEL, 32'h5555_5555, 5'd1, 1'b1,
                             '{ST_NOT_FOUND, 32'h0, 1'b0, 5'd16}});
        dir_rows.push_back('{REQ_DEL, 32'd111, 5'd1, 1'b0, '0});
        dir_rows.push_back('{REQ_DEL, 32'h7FFF_FFFF, 5'd1, 1'b0, '0});
        dir_rows.push_back('{REQ_DEL, 32'h8000_0000, 5'd1, 1'b0, '0});
        dir_rows.push_back('{REQ_ENQ, 32'd105, 5'd1, 1'b0, '0});
        dir_rows.push_back('{REQ_DEL, 32'd105, 5'd1, 1'b0, '0});
        dir_rows.push_back('{REQ_DEQ, 32'h0, 5'd2, 1'b0, '0});

        // hold reset, then release at an edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first phase: light sender gaps, heavy receiver stalls
        send_idle_pct  = 15;
        recv_stall_pct = 49;
        foreach (dir_rows[r])
            for (int k = 0; k < dir_rows[r].reps; k++)
                send_req(dir_rows[r].req, dir_rows[r].value + k, dir_rows[r].known,
                         dir_rows[r].res);
        run_random(RAND_ITEMS);
        drain_results();

        // second phase: heavy sender gaps, light receiver stalls
        send_idle_pct  = 49;
        recv_stall_pct = 15;
        run_random(RAND_ITEMS);
        drain_results();

        // last phase: no idling, but one long receiver hold to back up the input
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        run_random(RAND_ITEMS);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests and %0d results under three idling mixes and a long hold",
                 reqs_sent, results_seen);
        $display("status counts: ok %0d, empty %0d, not found %0d, full %0d",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_NOT_FOUND],
                 status_seen[ST_FULL]);
        if (mismatch_count == 0)
            $display("fifo_queue_with_value_delete_top_tb: done, clean");
        else
            $display("fifo_queue_with_value_delete_top_tb: done, errors");
        $finish;
    end

endmodule
